@@ rtl/core/csvdp_pkg.sv @@
// Shared types, constants and register map of the CSV decimal field parser.
package csvdp_pkg;

	// Accumulator width; results wrap modulo 2^VALUE_BITS (range 16..64).
	localparam int VALUE_BITS = 64;

	localparam int CHAR_BITS      = 8;
	localparam int FRAC_BITS      = 4;
	localparam int FIELD_NUM_BITS = 8;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 8;
	localparam int OUT_VALUE_BITS = 64;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_POINT = 8'h2E;

	localparam logic [FRAC_BITS-1:0]      FRAC_MAX      = 4'd15;
	localparam logic [FIELD_NUM_BITS-1:0] FIELD_NUM_MAX = 8'd255;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_ENABLE    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRACTION_DIGITS = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SEPARATOR_CHAR  = 2'd2;

	localparam logic                      RST_SCALE_ENABLE    = 1'b1;
	localparam logic [FRAC_BITS-1:0]      RST_FRACTION_DIGITS = 4'd5;
	localparam logic [CHAR_BITS-1:0]      RST_SEPARATOR_CHAR  = 8'd44;

	// Scaling pipeline: stage i multiplies by SCALE_STEP when bit SCALE_BIT
	// of the missing digit count is set. 10^8 is split over two 10^4 stages.
	localparam int SCALE_FIRST = 3;
	localparam int SCALE_LAST  = 7;
	localparam int SCALE_STAGES = SCALE_LAST - SCALE_FIRST + 1;
	localparam logic [VALUE_BITS-1:0] SCALE_STEP [SCALE_STAGES] = '{
		VALUE_BITS'(10), VALUE_BITS'(100), VALUE_BITS'(10000),
		VALUE_BITS'(10000), VALUE_BITS'(10000)
	};
	localparam int SCALE_BIT [SCALE_STAGES] = '{0, 1, 2, 3, 3};

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_MULTI_POINT = 2'd1,
		ERR_BAD_CHAR   = 2'd2
	} err_code_t;

	typedef struct packed {
		logic                 scale_enable;
		logic [FRAC_BITS-1:0] fraction_digits;
		logic [CHAR_BITS-1:0] separator_char;
	} cfg_t;

	// One closed field, handed from the field tracker to the scaler.
	typedef struct packed {
		logic [VALUE_BITS-1:0]     acc;
		logic [FRAC_BITS-1:0]      frac_cnt;
		err_code_t                 err;
		logic [FIELD_NUM_BITS-1:0] num;
		logic                      line_end;
	} field_rec_t;

endpackage

@@ rtl/core/csvdp_if.sv @@
// Channel interfaces: character input, field result output, config writes.
interface csvdp_in_if;
	logic                                valid;
	logic                                ready;
	logic [csvdp_pkg::CHAR_BITS-1:0]     char_in;
	logic                                line_end;

	modport source (output valid, char_in, line_end, input ready);
	modport sink   (input valid, char_in, line_end, output ready);
endinterface

interface csvdp_out_if;
	logic                                     valid;
	logic                                     ready;
	logic [csvdp_pkg::OUT_VALUE_BITS-1:0]     field_value;
	logic [1:0]                               error_code;
	logic [csvdp_pkg::FIELD_NUM_BITS-1:0]     field_number;
	logic                                     closes_line;

	modport source (output valid, field_value, error_code, field_number, closes_line,
		input ready);
	modport sink   (input valid, field_value, error_code, field_number, closes_line,
		output ready);
endinterface

interface csvdp_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [csvdp_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [csvdp_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/csv_decimal_field_parser.sv @@
// Top level of the CSV decimal field parser: config registers and datapath.
//
//  channel | dir | payload                                          | request
//  --------+-----+--------------------------------------------------+----------------------
//  in_ch   | in  | char_in[7:0], line_end                           | one byte of a line
//  out_ch  | out | field_value[63:0], error_code[1:0],              | one closed field
//          |     | field_number[7:0], closes_line                   |
//  cfg     | in  | index[1:0], data[7:0]                            | one register write
//
//  One byte is accepted per clock until a stall fills every stage; a field result
//  leaves through the input register, field close register and five scaling
//  stages. The field accumulator loop (value*10+digit) sets the rate.
//  Each stage takes data when it is empty or its successor moves, so an
//  output stall only stops input once every stage holds a request.
//  arst_n clears all valid flags, the field state and the config registers
//  (scale on, five fraction digits, comma separator).
module csv_decimal_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	csvdp_in_if.sink    in_ch,
	csvdp_out_if.source out_ch,
	csvdp_cfg_if.sink   cfg
);
	import csvdp_pkg::*;

	cfg_t       cfg_q;
	logic       rec_valid;
	logic       rec_ready;
	field_rec_t rec;

	// Config writes are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_enable    <= RST_SCALE_ENABLE;
			cfg_q.fraction_digits <= RST_FRACTION_DIGITS;
			cfg_q.separator_char  <= RST_SEPARATOR_CHAR;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SCALE_ENABLE:    cfg_q.scale_enable    <= cfg.data[0];
				CFG_FRACTION_DIGITS: cfg_q.fraction_digits <= cfg.data[FRAC_BITS-1:0];
				CFG_SEPARATOR_CHAR:  cfg_q.separator_char  <= cfg.data[CHAR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Byte-level field tracking; emits one record per non-empty closed field.
	csvdp_field u_field (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_q     (cfg_q),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	// When scale_enable is set, pads the fraction up to fraction_digits by multiplying by powers of ten.
	csvdp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_q     (cfg_q),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec),
		.out_ch    (out_ch)
	);

endmodule

@@ rtl/core/csvdp_field.sv @@
// Input register, per-field digit accumulator and closed-field register.
module csvdp_field (
	input  logic                  clk,
	input  logic                  arst_n,
	csvdp_in_if.sink              in_ch,
	input  csvdp_pkg::cfg_t       cfg_q,
	output logic                  rec_valid,
	input  logic                  rec_ready,
	output csvdp_pkg::field_rec_t rec
);
	import csvdp_pkg::*;

	// input stage
	logic                  valid_s1;
	logic [CHAR_BITS-1:0]  char_s1;
	logic                  le_s1;

	// field state
	logic [VALUE_BITS-1:0]     acc_q;
	logic                      point_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic                      nonempty_q;
	err_code_t                 err_q;
	logic [FIELD_NUM_BITS-1:0] idx_q;

	// closed-field stage
	logic       valid_s2;
	field_rec_t rec_s2;

	logic                  ready_s1, ready_s2, fire_s1;
	logic                  is_sep, is_digit, is_point, take, close, produce;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] acc_n;
	logic                  point_n, nonempty_n;
	logic [FRAC_BITS-1:0]  frac_n;
	err_code_t             err_n;

	assign ready_s2 = !valid_s2 || rec_ready;
	assign fire_s1  = valid_s1 && ready_s2;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;

	always_comb begin
		is_sep   = (char_s1 == cfg_q.separator_char);
		is_point = (char_s1 == CHAR_POINT);
		is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		digit    = 4'(char_s1 - CHAR_ZERO);
		take     = !is_sep;

		acc_n      = acc_q;
		point_n    = point_q;
		frac_n     = frac_q;
		err_n      = err_q;
		nonempty_n = nonempty_q | take;
		if (take) begin
			if (is_point) begin
				if (point_q && err_q == ERR_NONE) err_n = ERR_MULTI_POINT;
				point_n = 1'b1;
			end else if (is_digit) begin
				if (point_q && frac_q != FRAC_MAX) frac_n = frac_q + 4'd1;
				acc_n = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(digit);
			end else if (err_q == ERR_NONE) begin
				err_n = ERR_BAD_CHAR;
			end
		end
		close   = is_sep || le_s1;
		produce = close && nonempty_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_ch.valid) begin
			char_s1 <= in_ch.char_in;
			le_s1   <= in_ch.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			point_q    <= 1'b0;
			frac_q     <= '0;
			nonempty_q <= 1'b0;
			err_q      <= ERR_NONE;
			idx_q      <= '0;
		end else if (fire_s1) begin
			if (close) begin
				acc_q      <= '0;
				point_q    <= 1'b0;
				frac_q     <= '0;
				nonempty_q <= 1'b0;
				err_q      <= ERR_NONE;
				if (le_s1) begin
					idx_q <= '0;
				end else if (produce && idx_q != FIELD_NUM_MAX) begin
					idx_q <= idx_q + 8'd1;
				end
			end else begin
				acc_q      <= acc_n;
				point_q    <= point_n;
				frac_q     <= frac_n;
				nonempty_q <= nonempty_n;
				err_q      <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= fire_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			rec_s2.acc      <= acc_n;
			rec_s2.frac_cnt <= frac_n;
			rec_s2.err      <= err_n;
			rec_s2.num      <= idx_q;
			rec_s2.line_end <= le_s1;
		end
	end

	assign rec_valid = valid_s2;
	assign rec       = rec_s2;

`ifndef NO_ASSERTIONS
	// fraction digits are only counted after a point
	a_frac_needs_point: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q != '0 |-> point_q)
		else $error("fraction count set without a decimal point");

	// a line end always restarts field numbering
	a_line_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && le_s1 |=> idx_q == '0)
		else $error("field index not cleared at line end");
`endif

endmodule

@@ rtl/core/csvdp_scale.sv @@
// Fixed-point scaling pipeline: multiplies by 10^k over five short stages.
module csvdp_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csvdp_pkg::cfg_t       cfg_q,
	input  logic                  rec_valid,
	output logic                  rec_ready,
	input  csvdp_pkg::field_rec_t rec,
	csvdp_out_if.source           out_ch
);
	import csvdp_pkg::*;

	logic                      valid_s [SCALE_FIRST:SCALE_LAST];
	logic                      ready_s [SCALE_FIRST:SCALE_LAST];
	logic [VALUE_BITS-1:0]     value_s [SCALE_FIRST:SCALE_LAST];
	logic [FRAC_BITS-1:0]      k_s     [SCALE_FIRST:SCALE_LAST];
	err_code_t                 err_s   [SCALE_FIRST:SCALE_LAST];
	logic [FIELD_NUM_BITS-1:0] num_s   [SCALE_FIRST:SCALE_LAST];
	logic                      le_s    [SCALE_FIRST:SCALE_LAST];

	logic                 need_scale;
	logic [FRAC_BITS-1:0] k_in;
	logic [VALUE_BITS-1:0] value_in;

	// missing fraction digits; error fields go out as zero
	always_comb begin
		need_scale = cfg_q.scale_enable && (cfg_q.fraction_digits > rec.frac_cnt);
		k_in       = need_scale ? (cfg_q.fraction_digits - rec.frac_cnt) : '0;
		value_in   = (rec.err == ERR_NONE) ? rec.acc : '0;
	end

	assign rec_ready = ready_s[SCALE_FIRST];

	genvar i;
	generate
		for (i = SCALE_FIRST; i <= SCALE_LAST; i++) begin : g_stage
			logic                      src_valid;
			logic [VALUE_BITS-1:0]     src_value;
			logic [FRAC_BITS-1:0]      src_k;
			err_code_t                 src_err;
			logic [FIELD_NUM_BITS-1:0] src_num;
			logic                      src_le;
			logic                      next_ready;
			logic [VALUE_BITS-1:0]     step_value;

			if (i == SCALE_FIRST) begin : g_head
				assign src_valid = rec_valid;
				assign src_value = value_in;
				assign src_k     = k_in;
				assign src_err   = rec.err;
				assign src_num   = rec.num;
				assign src_le    = rec.line_end;
			end else begin : g_body
				assign src_valid = valid_s[i-1];
				assign src_value = value_s[i-1];
				assign src_k     = k_s[i-1];
				assign src_err   = err_s[i-1];
				assign src_num   = num_s[i-1];
				assign src_le    = le_s[i-1];
			end

			if (i == SCALE_LAST) begin : g_tail
				assign next_ready = out_ch.ready;
			end else begin : g_mid
				assign next_ready = ready_s[i+1];
			end

			assign ready_s[i]  = !valid_s[i] || next_ready;
			assign step_value = src_k[SCALE_BIT[i-SCALE_FIRST]]
				? src_value * SCALE_STEP[i-SCALE_FIRST] : src_value;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i] <= 1'b0;
				end else if (ready_s[i]) begin
					valid_s[i] <= src_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (ready_s[i] && src_valid) begin
					value_s[i] <= step_value;
					k_s[i]     <= src_k;
					err_s[i]   <= src_err;
					num_s[i]   <= src_num;
					le_s[i]    <= src_le;
				end
			end
		end
	endgenerate

	assign out_ch.valid        = valid_s[SCALE_LAST];
	assign out_ch.field_value  = OUT_VALUE_BITS'(value_s[SCALE_LAST]);
	assign out_ch.error_code   = err_s[SCALE_LAST];
	assign out_ch.field_number = num_s[SCALE_LAST];
	assign out_ch.closes_line  = le_s[SCALE_LAST];

`ifndef NO_ASSERTIONS
	// a field with an error never carries a value
	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[SCALE_LAST] && err_s[SCALE_LAST] != ERR_NONE
		|-> value_s[SCALE_LAST] == '0)
		else $error("error result with nonzero value");

	// a taken field record always lands in the first scaling stage
	a_rec_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready |=> valid_s[SCALE_FIRST])
		else $error("field record lost at scaler entry");
`endif

endmodule

@@ tb/sv/tb_csv_decimal_field_parser.sv @@
// Self-checking testbench of the CSV decimal field parser: directed table, then random lines.
`timescale 1ns / 100ps

module tb_csv_decimal_field_parser;
	import csvdp_pkg::*;

	// Generous cycle budget for the watchdog.
	localparam int CYCLE_LIMIT = 300000;
	// Settle past the result latency before touching registers.
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT = 4000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 92;
	localparam int WIDE_LINE_FIELDS = 300;

	// Index 3 is not mapped; writes to it must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

	// How a directed row is checked
	localparam logic [1:0] CHK_MODEL  = 2'd0;	// expectation from the predictor
	localparam logic [1:0] CHK_NONE   = 2'd1;	// no result for this byte
	localparam logic [1:0] CHK_RESULT = 2'd2;	// expectation typed in the row

	localparam logic [CHAR_BITS-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2F;	// just below '0'
	localparam logic [CHAR_BITS-1:0] CHAR_COLON = 8'h3A;	// just above '9'
	localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_BITS-1:0] CHAR_SEMI  = 8'h3B;

	typedef struct packed {
		logic [OUT_VALUE_BITS-1:0] value;
		err_code_t                 err;
		logic [FIELD_NUM_BITS-1:0] num;
		logic                      closes;
	} field_result_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] c;
		logic                 le;
		logic [1:0]           chk;
		field_result_t        want;
	} dir_row_t;

	// Directed table, run under the reset configuration (scale on, 5 digits, comma).
	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// single zero closed by line end
		'{CHAR_ZERO,  1'b1, CHK_RESULT, '{64'd0, ERR_NONE, 8'd0, 1'b1}},
		// two points, then a NUL: first error (multi point) is kept
		'{CHAR_POINT, 1'b0, CHK_NONE,   '0},
		'{CHAR_POINT, 1'b0, CHK_NONE,   '0},
		'{8'h00,      1'b0, CHK_NONE,   '0},
		'{CHAR_COMMA, 1'b0, CHK_RESULT, '{64'd0, ERR_MULTI_POINT, 8'd0, 1'b0}},
		// 0xFF is a bad char; separator as the last byte closes the line
		'{8'hFF,      1'b0, CHK_NONE,   '0},
		'{CHAR_COMMA, 1'b1, CHK_RESULT, '{64'd0, ERR_BAD_CHAR, 8'd1, 1'b1}},
		// empty field gives nothing and does not bump the field number
		'{CHAR_COMMA, 1'b0, CHK_NONE,   '0},
		// six fraction digits against five: no scaling, no truncation
		'{CHAR_ZERO + 8'd9, 1'b0, CHK_MODEL, '0},
		'{CHAR_POINT,       1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd1, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd2, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd3, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd4, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd5, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd6, 1'b1, CHK_RESULT, '{64'd9123456, ERR_NONE, 8'd0, 1'b1}},
		// plain integer scaled up
		'{CHAR_ZERO + 8'd4, 1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd2, 1'b1, CHK_MODEL, '0},
		// leading point
		'{CHAR_POINT,       1'b0, CHK_MODEL, '0},
		'{CHAR_ZERO + 8'd5, 1'b0, CHK_MODEL, '0},
		'{CHAR_COMMA,       1'b0, CHK_MODEL, '0},
		// chars right outside the digit range
		'{CHAR_ZERO + 8'd8, 1'b0, CHK_MODEL, '0},
		'{CHAR_SLASH,       1'b1, CHK_MODEL, '0},
		'{CHAR_COLON,       1'b1, CHK_RESULT, '{64'd0, ERR_BAD_CHAR, 8'd0, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	csvdp_in_if  in_ch();
	csvdp_out_if out_ch();
	csvdp_cfg_if cfg();

	csv_decimal_field_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Predictor copy of the configuration registers
	logic                 cfg_scale;
	logic [FRAC_BITS-1:0] cfg_frac;
	logic [CHAR_BITS-1:0] cfg_sep;

	// Predictor copy of the field state
	logic [VALUE_BITS-1:0]     acc_q;
	logic                      point_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic                      nonempty_q;
	err_code_t                 err_q;
	logic [FIELD_NUM_BITS-1:0] idx_q;

	field_result_t pending_fields[$];
	int            mismatches = 0;
	bit            in_idle;
	bit            out_idle;
	int            items_fed = 0;
	logic [8:0]    line_chars[$];	// {line_end, char}

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic void clear_field();
		acc_q = '0;
		point_q = 1'b0;
		frac_q = '0;
		nonempty_q = 1'b0;
		err_q = ERR_NONE;
	endfunction

	// Takes one accepted byte into the predicted state; returns 1 when a field closes
	// with a result, which then stands in res.
	function automatic bit parse_char(input logic [CHAR_BITS-1:0] c, input logic le,
		output field_result_t res);
		logic [VALUE_BITS-1:0] v;
		int                    n;
		bit                    is_sep;
		bit                    got;
		is_sep = (c == cfg_sep);
		got = 1'b0;
		res = '0;
		// the separator never joins a field, even when it looks like a digit or point
		if (!is_sep) begin
			nonempty_q = 1'b1;
			if (c == CHAR_POINT) begin
				if (point_q && err_q == ERR_NONE)
					err_q = ERR_MULTI_POINT;
				point_q = 1'b1;
			end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				if (point_q && frac_q < FRAC_MAX)
					frac_q = frac_q + 4'd1;
				acc_q = acc_q * VALUE_BITS'(10) + VALUE_BITS'(c - CHAR_ZERO);
			end else if (err_q == ERR_NONE) begin
				err_q = ERR_BAD_CHAR;
			end
		end
		if (is_sep || le) begin
			if (nonempty_q) begin
				v = acc_q;
				n = int'(frac_q);
				if (err_q != ERR_NONE) begin
					v = '0;
				end else if (cfg_scale) begin
					// pad up to the configured fraction digits, wrapping; never truncate
					while (n < int'(cfg_frac)) begin
						n++;
						v = v * VALUE_BITS'(10);
					end
				end
				res.value = OUT_VALUE_BITS'(v);
				res.err = err_q;
				res.num = idx_q;
				res.closes = le;
				got = 1'b1;
				if (idx_q < FIELD_NUM_MAX)
					idx_q = idx_q + 8'd1;
			end
			clear_field();
			if (le)
				idx_q = '0;
		end
		return got;
	endfunction

	// Offers one byte after a random gap (none unless in_idle) and waits for the request to be taken.
	// Leaves the caller right after the accepting edge with the prediction done.
	task automatic feed(input logic [CHAR_BITS-1:0] c, input logic le, output bit got,
		output field_result_t res);
		int gap;
		gap = in_idle ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.line_end <= le;
		do @(posedge clk); while (!in_ch.ready);
		got = parse_char(c, le, res);
		items_fed++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_SCALE_ENABLE:    cfg_scale = data[0];
			CFG_FRACTION_DIGITS: cfg_frac = data[FRAC_BITS-1:0];
			CFG_SEPARATOR_CHAR:  cfg_sep = data;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Sender holds off until every pending field is back or DRAIN_LIMIT runs out, then lets the pipe settle.
	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_fields.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic drive_line();
		bit            got;
		field_result_t res;
		while (line_chars.size() != 0) begin
			logic [8:0] item;
			item = line_chars.pop_front();
			feed(item[7:0], item[8], got, res);
			if (got)
				pending_fields.push_back(res);
		end
	endtask

	function automatic logic [CHAR_BITS-1:0] rand_digit();
		return CHAR_ZERO + CHAR_BITS'($urandom_range(0, 9));
	endfunction

	// Appends the bytes of one random field (no separator) to the line.
	function automatic void add_field();
		int kind;
		int len;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// empty field
		end else if (kind < 15) begin
			// noise: any byte at all
			len = $urandom_range(1, 4);
			repeat (len) line_chars.push_back({1'b0, CHAR_BITS'($urandom_range(0, 255))});
		end else if (kind < 20) begin
			// second point somewhere
			repeat ($urandom_range(0, 2)) line_chars.push_back({1'b0, rand_digit()});
			line_chars.push_back({1'b0, CHAR_POINT});
			repeat ($urandom_range(0, 2)) line_chars.push_back({1'b0, rand_digit()});
			line_chars.push_back({1'b0, CHAR_POINT});
			repeat ($urandom_range(0, 2)) line_chars.push_back({1'b0, rand_digit()});
		end else if (kind < 26) begin
			// long integer that may wrap past 2^64
			len = $urandom_range(18, 22);
			repeat (len) line_chars.push_back({1'b0, rand_digit()});
		end else if (kind < 30) begin
			// fraction count can run into its saturation
			line_chars.push_back({1'b0, rand_digit()});
			line_chars.push_back({1'b0, CHAR_POINT});
			len = $urandom_range(14, 18);
			repeat (len) line_chars.push_back({1'b0, rand_digit()});
		end else begin
			// well-formed number, optionally with a fraction
			repeat ($urandom_range(0, 6)) line_chars.push_back({1'b0, rand_digit()});
			if ($urandom_range(0, 1)) begin
				line_chars.push_back({1'b0, CHAR_POINT});
				repeat ($urandom_range(0, 6)) line_chars.push_back({1'b0, rand_digit()});
			end else if (line_chars.size() == 0 || line_chars[$][8]) begin
				line_chars.push_back({1'b0, rand_digit()});
			end
		end
	endfunction

	// Builds one line of random fields; the last byte carries line_end.
	function automatic void build_line();
		int nfields;
		int before_sz;
		nfields = $urandom_range(1, 6);
		for (int f = 0; f < nfields; f++) begin
			if (f != 0)
				line_chars.push_back({1'b0, cfg_sep});
			add_field();
		end
		before_sz = line_chars.size();
		// empty tail or a trailing separator: the separator itself ends the line
		if (before_sz == 0 || $urandom_range(0, 7) == 0)
			line_chars.push_back({1'b0, cfg_sep});
		line_chars[$][8] = 1'b1;
	endfunction

	task automatic set_config(input int ph);
		logic [FRAC_BITS-1:0] frac;
		logic [CHAR_BITS-1:0] sep;
		logic                 scale;
		case (ph % 4)
			0: frac = 4'd0;
			1: frac = 4'd9;
			2: frac = 4'd15;	// the largest setting, still wraps
			default: frac = FRAC_BITS'($urandom_range(0, 9));
		endcase
		case (ph % 8)
			0: sep = RST_SEPARATOR_CHAR;
			1: sep = rand_digit();	// a digit acts only as separator
			2: sep = CHAR_POINT;
			3: sep = 8'h00;
			4: sep = 8'hFF;
			5: sep = CHAR_BITS'($urandom_range(0, 255));
			6: sep = CHAR_TAB;
			default: sep = CHAR_SEMI;
		endcase
		scale = (ph % 3 != 1);
		// upper data bits are don't-care for the narrow registers; toggle them anyway
		write_reg(CFG_SCALE_ENABLE, {7'($urandom_range(0, 127)), scale});
		write_reg(CFG_FRACTION_DIGITS, {4'($urandom_range(0, 15)), frac});
		write_reg(CFG_SEPARATOR_CHAR, sep);
		write_reg(CFG_UNMAPPED, CFG_DATA_BITS'($urandom_range(0, 255)));
	endtask

	// Output side: random stall before each result, none in phases that run flat out.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = out_idle ? $urandom_range(0, 6) : 0;
			@(negedge clk);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Result checker: every accepted result against the oldest pending field.
	always @(posedge clk) begin
		field_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_fields.size() == 0) begin
				report("result with no field pending", out_ch.field_value, '0);
			end else begin
				want = pending_fields.pop_front();
				if (out_ch.field_value !== want.value)
					report("field_value", out_ch.field_value, want.value);
				if (out_ch.error_code !== want.err)
					report("error_code", 64'(out_ch.error_code), 64'(want.err));
				if (out_ch.field_number !== want.num)
					report("field_number", 64'(out_ch.field_number), 64'(want.num));
				if (out_ch.closes_line !== want.closes)
					report("closes_line", 64'(out_ch.closes_line), 64'(want.closes));
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		bit            got;
		field_result_t res;
		int            start_items;
		// every input known from time zero
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.char_in = '0;
		in_ch.line_end = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		in_idle = 1'b1;
		out_idle = 1'b1;
		cfg_scale = RST_SCALE_ENABLE;
		cfg_frac = RST_FRACTION_DIGITS;
		cfg_sep = RST_SEPARATOR_CHAR;
		clear_field();
		idx_q = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under reset configuration
		for (int i = 0; i < DIR_ROWS; i++) begin
			feed(DIRECTED[i].c, DIRECTED[i].le, got, res);
			case (DIRECTED[i].chk)
				CHK_MODEL:  if (got) pending_fields.push_back(res);
				CHK_RESULT: pending_fields.push_back(DIRECTED[i].want);
				default: ;
			endcase
		end
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_config(ph);
			// mostly idling on both sides, with some phases running flat out
			in_idle = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			out_idle = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (ph == 4) begin
				// more than 255 fields in one line: field_number must saturate
				write_reg(CFG_SEPARATOR_CHAR, RST_SEPARATOR_CHAR);
				for (int f = 0; f < WIDE_LINE_FIELDS; f++) begin
					line_chars.push_back({1'b0, rand_digit()});
					if (f != WIDE_LINE_FIELDS - 1)
						line_chars.push_back({1'b0, cfg_sep});
				end
				line_chars[$][8] = 1'b1;
				drive_line();
			end else begin
				start_items = items_fed;
				while (items_fed - start_items < PHASE_ITEMS) begin
					build_line();
					drive_line();
				end
			end
			drain();
		end

		// anything still pending now never came
		while (pending_fields.size() != 0) begin
			res = pending_fields.pop_front();
			report("field never reported", '0, res.value);
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ csv_decimal_field_parser.f @@
rtl/core/csvdp_pkg.sv
rtl/core/csvdp_if.sv
rtl/core/csvdp_field.sv
rtl/core/csvdp_scale.sv
rtl/core/csv_decimal_field_parser.sv
tb/sv/tb_csv_decimal_field_parser.sv
